// ----- rtl/swtb_pkg.sv -----
// Shared constants, operation and result codes, and the command and status
// structures that join the timer bank controller and datapath.
// No dependencies.
package swtb_pkg;

  localparam int TIMER_COUNT_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int OP_W       = 3;
  localparam int SLOT_W     = 8;
  localparam int FIELD_W    = 16;
  localparam int KIND_W     = 2;
  localparam int SLOT_OUT_W = 3;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_START  = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

  // Source of the slot number reported in a result.
  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_SLOT = 2'd1;
  localparam logic [1:0] SEL_IDX  = 2'd2;

  typedef struct packed {
    logic              load_item;
    logic              idx_clr;
    logic              idx_inc;
    logic              create_wr;
    logic              cmd_apply;
    logic              tick_dec;
    logic              tick_fire;
    logic              pend_set;
    logic [KIND_W-1:0] pend_kind;
    logic [1:0]        pend_sel;
    logic              pend_last;
    logic              out_load;
  } swtb_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            slot_bad;
    logic            slot_used;
    logic            idx_end;
    logic            idx_used;
    logic            idx_run;
    logic            ticks_zero;
    logic            out_space;
    logic            pend_last;
  } swtb_stat_t;

endpackage

// ----- rtl/swtb_if.sv -----
// Valid/ready channel interfaces for the timer bank: command items in,
// result items out. Depends on swtb_pkg for the field widths.
interface swtb_in_if;
  logic                         valid;
  logic                         ready;
  logic [swtb_pkg::OP_W-1:0]    opcode;
  logic [swtb_pkg::SLOT_W-1:0]  slot;
  logic [swtb_pkg::FIELD_W-1:0] delay_ticks;
  logic [swtb_pkg::FIELD_W-1:0] period_ticks;
  logic                         start_running;

  modport source (output valid, opcode, slot, delay_ticks, period_ticks, start_running,
                  input ready);
  modport sink (input valid, opcode, slot, delay_ticks, period_ticks, start_running,
                output ready);
endinterface

interface swtb_out_if;
  logic                            valid;
  logic                            ready;
  logic [swtb_pkg::KIND_W-1:0]     result_kind;
  logic [swtb_pkg::SLOT_OUT_W-1:0] slot_out;
  logic                            last;

  modport source (output valid, result_kind, slot_out, last, input ready);
  modport sink (input valid, result_kind, slot_out, last, output ready);
endinterface

// ----- rtl/swtb_dp.sv -----
// Timer bank datapath: captured item, slot flags, delay and period memories,
// slot walk counter, pending result and output register. Depends on swtb_pkg.
module swtb_dp #(
  parameter int TIMER_COUNT = swtb_pkg::TIMER_COUNT_DEF,
  parameter int COUNT_WIDTH = swtb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  swtb_pkg::swtb_cmd_t             cmd,
  output swtb_pkg::swtb_stat_t            stat,
  input  logic [swtb_pkg::OP_W-1:0]       in_opcode,
  input  logic [swtb_pkg::SLOT_W-1:0]     in_slot,
  input  logic [swtb_pkg::FIELD_W-1:0]    in_delay_ticks,
  input  logic [swtb_pkg::FIELD_W-1:0]    in_period_ticks,
  input  logic                            in_start_running,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [swtb_pkg::KIND_W-1:0]     out_result_kind,
  output logic [swtb_pkg::SLOT_OUT_W-1:0] out_slot_out,
  output logic                            out_last
);

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CW = $clog2(TIMER_COUNT + 1);

  logic [swtb_pkg::OP_W-1:0]       op_r;
  logic [swtb_pkg::SLOT_W-1:0]     slot_r;
  logic [swtb_pkg::FIELD_W-1:0]    delay_r;
  logic [swtb_pkg::FIELD_W-1:0]    period_r;
  logic                            start_r;
  logic [TIMER_COUNT-1:0]          used_r;
  logic [TIMER_COUNT-1:0]          used_nxt;
  logic [TIMER_COUNT-1:0]          run_r;
  logic [TIMER_COUNT-1:0]          run_nxt;
  logic [CW-1:0]                   idx_r;
  logic [COUNT_WIDTH-1:0]          ticks_mem [TIMER_COUNT];
  logic [COUNT_WIDTH-1:0]          reload_mem [TIMER_COUNT];
  logic [COUNT_WIDTH-1:0]          rd_ticks_r;
  logic [COUNT_WIDTH-1:0]          rd_reload_r;
  logic [COUNT_WIDTH-1:0]          wr_ticks;
  logic                            ticks_we;
  logic                            reload_zero;
  logic [IW-1:0]                   ix;
  logic [IW-1:0]                   sx;
  logic [swtb_pkg::KIND_W-1:0]     pend_kind_r;
  logic [swtb_pkg::SLOT_OUT_W-1:0] pend_slot_r;
  logic [swtb_pkg::SLOT_OUT_W-1:0] pend_slot;
  logic                            pend_last_r;
  logic                            out_valid_r;
  logic [swtb_pkg::KIND_W-1:0]     out_kind_r;
  logic [swtb_pkg::SLOT_OUT_W-1:0] out_slot_r;
  logic                            out_last_r;

  assign ix          = idx_r[IW-1:0];
  assign sx          = slot_r[IW-1:0];
  assign reload_zero = (rd_reload_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r     <= in_opcode;
      slot_r   <= in_slot;
      delay_r  <= in_delay_ticks;
      period_r <= in_period_ticks;
      start_r  <= in_start_running;
    end
  end

  always_comb begin
    used_nxt = used_r;
    run_nxt  = run_r;
    if (cmd.create_wr) begin
      used_nxt[ix] = 1'b1;
      run_nxt[ix]  = start_r;
    end
    if (cmd.cmd_apply) begin
      unique case (op_r)
        swtb_pkg::OP_DELETE: begin
          used_nxt[sx] = 1'b0;
          run_nxt[sx]  = 1'b0;
        end
        swtb_pkg::OP_START: run_nxt[sx] = 1'b1;
        swtb_pkg::OP_STOP:  run_nxt[sx] = 1'b0;
        default: ;
      endcase
    end
    if (cmd.tick_fire && reload_zero) begin
      used_nxt[ix] = 1'b0;
      run_nxt[ix]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      run_r  <= '0;
      idx_r  <= '0;
    end else begin
      used_r <= used_nxt;
      run_r  <= run_nxt;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
    end
  end

  always_comb begin
    if (cmd.create_wr) begin
      wr_ticks = COUNT_WIDTH'(delay_r);
    end else if (cmd.tick_fire) begin
      wr_ticks = rd_reload_r;
    end else begin
      wr_ticks = rd_ticks_r - COUNT_WIDTH'(1);
    end
  end

  assign ticks_we = cmd.create_wr | cmd.tick_dec | (cmd.tick_fire & ~reload_zero);

  always_ff @(posedge clk) begin
    if (ticks_we) begin
      ticks_mem[ix] <= wr_ticks;
    end
    if (cmd.create_wr) begin
      reload_mem[ix] <= COUNT_WIDTH'(period_r);
    end
    rd_ticks_r  <= ticks_mem[ix];
    rd_reload_r <= reload_mem[ix];
  end

  always_comb begin
    unique case (cmd.pend_sel)
      swtb_pkg::SEL_SLOT: pend_slot = slot_r[swtb_pkg::SLOT_OUT_W-1:0];
      swtb_pkg::SEL_IDX:  pend_slot = swtb_pkg::SLOT_OUT_W'(idx_r);
      default:            pend_slot = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_kind_r <= cmd.pend_kind;
      pend_slot_r <= pend_slot;
      pend_last_r <= cmd.pend_last;
    end
    if (cmd.out_load) begin
      out_kind_r <= pend_kind_r;
      out_slot_r <= pend_slot_r;
      out_last_r <= pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_slot_out    = out_slot_r;
  assign out_last        = out_last_r;

  assign stat.op         = op_r;
  assign stat.slot_bad   = (slot_r >= swtb_pkg::SLOT_W'(TIMER_COUNT));
  assign stat.slot_used  = used_r[sx];
  assign stat.idx_end    = (idx_r == CW'(TIMER_COUNT));
  assign stat.idx_used   = used_r[ix];
  assign stat.idx_run    = run_r[ix];
  assign stat.ticks_zero = (rd_ticks_r == '0);
  assign stat.out_space  = ~out_valid_r | out_ready;
  assign stat.pend_last  = pend_last_r;

endmodule

// ----- rtl/swtb_ctrl.sv -----
// Timer bank controller: state machine that decodes each item, walks the
// slots for create and tick, and issues datapath commands. Depends on swtb_pkg.
module swtb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  swtb_pkg::swtb_stat_t stat,
  output swtb_pkg::swtb_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_CREATE = 3'd2;
  localparam logic [2:0] ST_TK_RD  = 3'd3;
  localparam logic [2:0] ST_TK_EV  = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (stat.op == swtb_pkg::OP_CREATE) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_CREATE;
        end else if (stat.op == swtb_pkg::OP_DELETE || stat.op == swtb_pkg::OP_START ||
                     stat.op == swtb_pkg::OP_STOP) begin
          cmd.pend_set  = 1'b1;
          cmd.pend_sel  = swtb_pkg::SEL_SLOT;
          cmd.pend_last = 1'b1;
          if (stat.slot_bad || !stat.slot_used) begin
            cmd.pend_kind = swtb_pkg::KIND_REJECT;
          end else begin
            cmd.cmd_apply = 1'b1;
            cmd.pend_kind = swtb_pkg::KIND_ACCEPT;
          end
          state_nxt = ST_EMIT;
        end else if (stat.op == swtb_pkg::OP_TICK) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_TK_RD;
        end else begin
          cmd.pend_set  = 1'b1;
          cmd.pend_sel  = swtb_pkg::SEL_ZERO;
          cmd.pend_kind = swtb_pkg::KIND_REJECT;
          cmd.pend_last = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_CREATE: begin
        priority if (stat.idx_end) begin
          cmd.pend_set  = 1'b1;
          cmd.pend_sel  = swtb_pkg::SEL_ZERO;
          cmd.pend_kind = swtb_pkg::KIND_REJECT;
          cmd.pend_last = 1'b1;
          state_nxt     = ST_EMIT;
        end else if (!stat.idx_used) begin
          cmd.create_wr = 1'b1;
          cmd.pend_set  = 1'b1;
          cmd.pend_sel  = swtb_pkg::SEL_IDX;
          cmd.pend_kind = swtb_pkg::KIND_ACCEPT;
          cmd.pend_last = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_TK_RD: begin
        priority if (stat.idx_end) begin
          cmd.pend_set  = 1'b1;
          cmd.pend_sel  = swtb_pkg::SEL_ZERO;
          cmd.pend_kind = swtb_pkg::KIND_DONE;
          cmd.pend_last = 1'b1;
          state_nxt     = ST_EMIT;
        end else if (!stat.idx_used) begin
          cmd.idx_inc = 1'b1;
        end else begin
          state_nxt = ST_TK_EV;
        end
      end
      ST_TK_EV: begin
        cmd.idx_inc = 1'b1;
        state_nxt   = ST_TK_RD;
        if (stat.ticks_zero) begin
          if (stat.idx_run) begin
            cmd.tick_fire = 1'b1;
            cmd.pend_set  = 1'b1;
            cmd.pend_sel  = swtb_pkg::SEL_IDX;
            cmd.pend_kind = swtb_pkg::KIND_FIRED;
            cmd.pend_last = 1'b0;
            state_nxt     = ST_EMIT;
          end
        end else begin
          cmd.tick_dec = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.out_space) begin
          cmd.out_load = 1'b1;
          state_nxt    = stat.pend_last ? ST_IDLE : ST_TK_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/software_timer_bank_unit.sv -----
// Top level of the software timer bank: joins the controller and datapath to
// the command and result channels. Depends on swtb_pkg, swtb_if, swtb_ctrl, swtb_dp.
//
//   Channel    Direction  Carries
//   in_chan    sink       opcode, slot, delay_ticks, period_ticks, start_running
//   out_chan   source     result_kind, slot_out, last
//
// One item is taken at a time; the next is accepted once the last result of
// the previous one is in the output register. Create walks the slots from
// zero to the first free one; delete, start and stop go from decode straight
// to emit. A tick visits an unused slot in ST_TK_RD only and a used slot in
// ST_TK_RD and then ST_TK_EV, since the tick memory read is registered, and it
// passes through ST_EMIT for each firing.
// Reset (synchronous, active low) empties every slot. A stalled output holds
// the walk at the pending result.
module software_timer_bank_unit #(
  parameter int TIMER_COUNT = swtb_pkg::TIMER_COUNT_DEF,
  parameter int COUNT_WIDTH = swtb_pkg::COUNT_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  swtb_in_if.sink   in_chan,
  swtb_out_if.source out_chan
);

  swtb_pkg::swtb_cmd_t  cmd;
  swtb_pkg::swtb_stat_t stat;
  logic                 in_ready;

  assign in_chan.ready = in_ready;

  swtb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swtb_dp #(
    .TIMER_COUNT (TIMER_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_chan.opcode),
    .in_slot          (in_chan.slot),
    .in_delay_ticks   (in_chan.delay_ticks),
    .in_period_ticks  (in_chan.period_ticks),
    .in_start_running (in_chan.start_running),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_result_kind  (out_chan.result_kind),
    .out_slot_out     (out_chan.slot_out),
    .out_last         (out_chan.last)
  );

endmodule

// ----- tb/software_timer_bank_unit_checker.sv -----
`timescale 1ns / 1ps
// Transaction checker for the software timer bank: keeps its own copy of the slot table,
// predicts the results of every accepted command and compares them with the result channel.
// Depends on swtb_pkg and the channel interfaces in swtb_if.
module software_timer_bank_unit_checker #(
  parameter int TIMERS = swtb_pkg::TIMER_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  swtb_in_if   in_mon,
  swtb_out_if  out_mon,
  output int   fail_count,
  output int   pending_results,
  output int   cmd_count,
  output int   result_count,
  output int   fire_count,
  output int   reject_count
);

  typedef struct packed {
    logic [swtb_pkg::KIND_W-1:0]     kind;
    logic [swtb_pkg::SLOT_OUT_W-1:0] slot;
    logic                            last;
  } timer_result_t;

  logic                                 slot_taken [TIMERS];
  logic                                 slot_running [TIMERS];
  logic [swtb_pkg::COUNT_WIDTH_DEF-1:0] ticks_remaining [TIMERS];
  logic [swtb_pkg::COUNT_WIDTH_DEF-1:0] reload_ticks [TIMERS];

  timer_result_t awaited_results [$];
  timer_result_t oldest;

  function automatic void await_result(logic [swtb_pkg::KIND_W-1:0] kind,
                                       logic [swtb_pkg::SLOT_OUT_W-1:0] slot, logic last);
    timer_result_t r;
    r.kind = kind;
    r.slot = slot;
    r.last = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void free_timer(int s);
    slot_taken[s] = 1'b0;
    slot_running[s] = 1'b0;
    ticks_remaining[s] = '0;
    reload_ticks[s] = '0;
  endfunction

  function automatic void clear_table();
    for (int s = 0; s < TIMERS; s++) begin
      free_timer(s);
    end
  endfunction

  function automatic void predict_timer_command(logic [swtb_pkg::OP_W-1:0] op,
                                                logic [swtb_pkg::SLOT_W-1:0] slot,
                                                logic [swtb_pkg::FIELD_W-1:0] delay,
                                                logic [swtb_pkg::FIELD_W-1:0] period,
                                                logic run);
    int free_idx;
    int target;
    free_idx = -1;
    target = int'(slot);
    case (op)
      swtb_pkg::OP_CREATE: begin
        for (int s = TIMERS - 1; s >= 0; s--) begin
          if (!slot_taken[s]) free_idx = s;
        end
        if (free_idx < 0) begin
          await_result(swtb_pkg::KIND_REJECT, '0, 1'b1);
        end else begin
          slot_taken[free_idx] = 1'b1;
          slot_running[free_idx] = run;
          ticks_remaining[free_idx] = delay[swtb_pkg::COUNT_WIDTH_DEF-1:0];
          reload_ticks[free_idx] = period[swtb_pkg::COUNT_WIDTH_DEF-1:0];
          await_result(swtb_pkg::KIND_ACCEPT, free_idx[swtb_pkg::SLOT_OUT_W-1:0], 1'b1);
        end
      end
      swtb_pkg::OP_DELETE, swtb_pkg::OP_START, swtb_pkg::OP_STOP: begin
        if (target >= TIMERS) begin
          await_result(swtb_pkg::KIND_REJECT, slot[swtb_pkg::SLOT_OUT_W-1:0], 1'b1);
        end else if (!slot_taken[target]) begin
          await_result(swtb_pkg::KIND_REJECT, slot[swtb_pkg::SLOT_OUT_W-1:0], 1'b1);
        end else begin
          if (op == swtb_pkg::OP_DELETE) begin
            free_timer(target);
          end else begin
            slot_running[target] = (op == swtb_pkg::OP_START);
          end
          await_result(swtb_pkg::KIND_ACCEPT, slot[swtb_pkg::SLOT_OUT_W-1:0], 1'b1);
        end
      end
      swtb_pkg::OP_TICK: begin
        for (int s = 0; s < TIMERS; s++) begin
          if (slot_taken[s]) begin
            if (ticks_remaining[s] == '0) begin
              if (slot_running[s]) begin
                await_result(swtb_pkg::KIND_FIRED, s[swtb_pkg::SLOT_OUT_W-1:0], 1'b0);
                if (reload_ticks[s] == '0) begin
                  free_timer(s);
                end else begin
                  ticks_remaining[s] = reload_ticks[s];
                end
              end
            end else begin
              ticks_remaining[s] = ticks_remaining[s] - 1'b1;
            end
          end
        end
        await_result(swtb_pkg::KIND_DONE, '0, 1'b1);
      end
      default: begin
        await_result(swtb_pkg::KIND_REJECT, '0, 1'b1);
      end
    endcase
  endfunction

  initial begin
    fail_count = 0;
    pending_results = 0;
    cmd_count = 0;
    result_count = 0;
    fire_count = 0;
    reject_count = 0;
    clear_table();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (out_mon.result_kind == swtb_pkg::KIND_FIRED) fire_count++;
        if (out_mon.result_kind == swtb_pkg::KIND_REJECT) reject_count++;
        if (awaited_results.size() == 0) begin
          $error("Unexpected result transaction: result_kind %0d, slot_out %0d, last %0d",
                 out_mon.result_kind, out_mon.slot_out, out_mon.last);
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_mon.result_kind !== oldest.kind) begin
            $error("result_kind mismatch: expected %0d, actual %0d",
                   oldest.kind, out_mon.result_kind);
            fail_count++;
          end
          if (out_mon.slot_out !== oldest.slot) begin
            $error("slot_out mismatch: expected %0d, actual %0d", oldest.slot, out_mon.slot_out);
            fail_count++;
          end
          if (out_mon.last !== oldest.last) begin
            $error("last mismatch: expected %0d, actual %0d", oldest.last, out_mon.last);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        cmd_count++;
        predict_timer_command(in_mon.opcode, in_mon.slot, in_mon.delay_ticks,
                              in_mon.period_ticks, in_mon.start_running);
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

// ----- tb/software_timer_bank_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the software timer bank testbench: clock, reset, command stimulus and result
// back-pressure, with the verdict taken from software_timer_bank_unit_checker.
// Depends on swtb_pkg, swtb_if, the block and the checker.
module software_timer_bank_unit_tb;

  localparam logic [swtb_pkg::OP_W-1:0] OP_FIRST_UNUSED = swtb_pkg::OP_TICK + 1'b1;
  localparam logic [swtb_pkg::OP_W-1:0] OP_LAST_CODE    = '1;
  localparam int                        HOLD_CYCLES     = 150;

  logic clk = 1'b0;
  logic rst_n;

  int send_idle_pct;
  int recv_idle_pct;
  logic hold_req;
  logic hold_taken;
  int hold_left;

  int fail_count;
  int pending_results;
  int cmd_count;
  int result_count;
  int fire_count;
  int reject_count;

  swtb_in_if  in_chan ();
  swtb_out_if out_chan ();

  software_timer_bank_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  software_timer_bank_unit_checker checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .cmd_count      (cmd_count),
    .result_count   (result_count),
    .fire_count     (fire_count),
    .reject_count   (reject_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_chan.ready = 1'b0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_cmd(input logic [swtb_pkg::OP_W-1:0] op,
                          input logic [swtb_pkg::SLOT_W-1:0] slot,
                          input logic [swtb_pkg::FIELD_W-1:0] delay,
                          input logic [swtb_pkg::FIELD_W-1:0] period,
                          input logic run);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.opcode <= op;
    in_chan.slot <= slot;
    in_chan.delay_ticks <= delay;
    in_chan.period_ticks <= period;
    in_chan.start_running <= run;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (pending_results == 0);
  endtask

  task automatic send_random_cmd();
    int pick;
    logic [swtb_pkg::OP_W-1:0] op;
    logic [swtb_pkg::SLOT_W-1:0] slot;
    logic [swtb_pkg::FIELD_W-1:0] delay;
    logic [swtb_pkg::FIELD_W-1:0] period;
    pick = $urandom_range(0, 99);
    if (pick < 22) op = swtb_pkg::OP_CREATE;
    else if (pick < 32) op = swtb_pkg::OP_DELETE;
    else if (pick < 44) op = swtb_pkg::OP_START;
    else if (pick < 54) op = swtb_pkg::OP_STOP;
    else if (pick < 97) op = swtb_pkg::OP_TICK;
    else op = swtb_pkg::OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
    if ($urandom_range(0, 9) == 0) slot = swtb_pkg::SLOT_W'($urandom_range(0, 255));
    else slot = swtb_pkg::SLOT_W'($urandom_range(0, swtb_pkg::TIMER_COUNT_DEF - 1));
    pick = $urandom_range(0, 9);
    if (pick < 7) delay = swtb_pkg::FIELD_W'($urandom_range(0, 3));
    else if (pick < 9) delay = swtb_pkg::FIELD_W'($urandom);
    else delay = '1;
    pick = $urandom_range(0, 9);
    if (pick < 4) period = '0;
    else if (pick < 8) period = swtb_pkg::FIELD_W'($urandom_range(1, 4));
    else period = swtb_pkg::FIELD_W'($urandom);
    send_cmd(op, slot, delay, period, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_n = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 55;
    in_chan.valid = 1'b0;
    in_chan.opcode = swtb_pkg::OP_TICK;
    in_chan.slot = '0;
    in_chan.delay_ticks = '0;
    in_chan.period_ticks = '0;
    in_chan.start_running = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_cmd(swtb_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_DELETE, 8'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_START, 8'hFF, 16'd0, 16'd0, 1'b1);
    send_cmd(swtb_pkg::OP_STOP, 8'd8, 16'd0, 16'd0, 1'b0);
    send_cmd(OP_FIRST_UNUSED, 8'd3, 16'd1, 16'd1, 1'b1);
    send_cmd(OP_LAST_CODE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_cmd(swtb_pkg::OP_CREATE, 8'd0, 16'd0, 16'd0, 1'b1);
    send_cmd(swtb_pkg::OP_CREATE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_cmd(swtb_pkg::OP_CREATE, 8'd0, 16'd1, 16'd2, 1'b1);
    send_cmd(swtb_pkg::OP_CREATE, 8'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_CREATE, 8'd0, 16'd0, 16'd3, 1'b1);
    send_cmd(swtb_pkg::OP_CREATE, 8'd0, 16'd2, 16'd0, 1'b1);
    send_cmd(swtb_pkg::OP_CREATE, 8'd0, 16'd5, 16'd1, 1'b1);
    send_cmd(swtb_pkg::OP_CREATE, 8'd0, 16'd0, 16'd1, 1'b1);
    send_cmd(swtb_pkg::OP_CREATE, 8'd0, 16'd7, 16'd7, 1'b1);
    send_cmd(swtb_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_START, 8'd3, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_STOP, 8'd2, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_DELETE, 8'd1, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_CREATE, 8'd0, 16'hAAAA, 16'h5555, 1'b1);
    send_cmd(swtb_pkg::OP_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
    send_cmd(swtb_pkg::OP_START, 8'd1, 16'd0, 16'd0, 1'b1);
    send_cmd(swtb_pkg::OP_DELETE, 8'd7, 16'd0, 16'd0, 1'b0);

    repeat (80) send_random_cmd();
    drain_results();

    send_idle_pct = 55;
    recv_idle_pct = 24;
    repeat (80) send_random_cmd();
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (80) send_random_cmd();
    drain_results();
    repeat (40) @(posedge clk);

    $display("Run summary: %0d commands and %0d results checked, %0d firings, %0d rejections,",
             cmd_count, result_count, fire_count, reject_count);
    $display("  over three idling patterns, one long result stall and drained pauses.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
